FILE: design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LBCI_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbci assertion failed");

// next-cycle implication, disabled during reset
`define LBCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbci assertion failed");

`endif

FILE: design/lbci_pkg.sv
// ----------------------------------------------------------------------------
// lbci_pkg
// types and constants of the led blink code indicator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbci_pkg;

  localparam int unsigned CodeW  = 4;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned PatW   = 4;
  localparam int unsigned TimerW = 16;
  localparam int unsigned PauseW = 4;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CodeW-1:0]    code_t;
  typedef logic [PatW-1:0]     pat_t;
  typedef logic [TimerW-1:0]   timer_t;
  typedef logic [PauseW-1:0]   pause_t;
  typedef logic signed [CountW-1:0] count_t;
  typedef logic [CfgAddrW-1:0] cfg_addr_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BLINK_PERIOD  = 2'd0,
    REG_DARK_AFTER    = 2'd1,
    REG_PAUSE_SLOTS   = 2'd2,
    REG_CHANGE_FLASH  = 2'd3
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF     = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_SPIN    = 3'd2,
    MODE_SUN     = 3'd3,
    MODE_SUN_SIM = 3'd4
  } mode_e;

  localparam timer_t RstBlinkPeriod = 16'd3500;
  localparam timer_t RstDarkAfter   = 16'd1000;
  localparam pause_t RstPauseSlots  = 4'd5;
  localparam timer_t RstChangeFlash = 16'd2500;

  localparam code_t NoError = '0;

  localparam pat_t PatDark       = 4'h0;
  localparam pat_t PatGreenBoth  = 4'h5;
  localparam pat_t PatRedBoth    = 4'hA;
  localparam pat_t PatFront      = 4'h9;
  localparam pat_t PatRear       = 4'h6;

endpackage

`default_nettype wire

FILE: design/lbci_cfg_if.sv
// ----------------------------------------------------------------------------
// lbci_cfg_if
// register write channel of the led blink code indicator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbci_cfg_if;
  logic                valid;
  logic                ready;
  lbci_pkg::cfg_addr_t addr;
  lbci_pkg::cfg_data_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lbci_in_if.sv
// ----------------------------------------------------------------------------
// lbci_in_if
// tick channel of the led blink code indicator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbci_in_if;
  logic                              valid;
  logic                              ready;
  logic [lbci_pkg::CodeW-1:0]        error_code;
  logic [lbci_pkg::ModeW-1:0]        system_mode;
  logic                              angle_bit;
  logic [lbci_pkg::PhaseW-1:0]       rotation_phase;

  modport source (output valid, output error_code, output system_mode,
                  output angle_bit, output rotation_phase, input ready);
  modport sink   (input valid, input error_code, input system_mode,
                  input angle_bit, input rotation_phase, output ready);
endinterface

`default_nettype wire

FILE: design/lbci_out_if.sv
// ----------------------------------------------------------------------------
// lbci_out_if
// result channel of the led blink code indicator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbci_out_if;
  logic                       valid;
  logic                       ready;
  logic [lbci_pkg::PatW-1:0]  led_pattern;
  logic [lbci_pkg::CodeW-1:0] shown_error;

  modport source (output valid, output led_pattern, output shown_error, input ready);
  modport sink   (input valid, input led_pattern, input shown_error, output ready);
endinterface

`default_nettype wire

FILE: design/led_blink_code_indicator.sv
// ----------------------------------------------------------------------------
// led_blink_code_indicator
// error blink codes and mode patterns for four status leds
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one timer tick per transfer, with an optional error report,
//   the system mode, the spin angle bit and the rotation phase.
//   out_o returns one result per tick: the led pattern and the error code
//   currently blinked.
//   cfg_i writes blink_period, dark_after, pause_slots and change_flash_ticks
//   by register index; write only while no tick is in flight.
// timing:
//   out_o.valid rises in the cycle after the input transfer; a new tick is
//   taken every cycle unless out_o stalls, set by the single state update register stage.
// reset:
//   no error held, counters cleared, previous mode off, registers at their
//   defaults (3500, 1000, 5, 2500), output register empty.
// stall:
//   when out_o.ready is low with a result waiting, in_i.ready drops and the
//   result holds until it is taken; ready returns in the cycle it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_blink_code_indicator (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbci_cfg_if.sink   cfg_i,
  lbci_in_if.sink    in_i,
  lbci_out_if.source out_o
);
  import lbci_pkg::*;

  timer_t blink_period_q, dark_after_q, change_flash_q;
  pause_t pause_slots_q;

  code_t                active_q, active_d, pending_q, pending_d;
  timer_t               slot_q, slot_d, change_q, change_d;
  count_t               count_q, count_d;
  logic [ModeW-1:0]     prev_mode_q, prev_mode_d;
  logic                 out_valid_q;
  pat_t                 pat_q, pat_d;
  code_t                shown_q;

  logic                 in_ready;
  logic                 in_fire;
  code_t                code;
  code_t                act_l, pend_l;
  timer_t               slot_inc, chg_l;
  count_t               cnt_inc;
  logic                 dark;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q <= RstBlinkPeriod;
      dark_after_q   <= RstDarkAfter;
      pause_slots_q  <= RstPauseSlots;
      change_flash_q <= RstChangeFlash;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        REG_BLINK_PERIOD: blink_period_q <= cfg_i.data;
        REG_DARK_AFTER:   dark_after_q   <= cfg_i.data;
        REG_PAUSE_SLOTS:  pause_slots_q  <= cfg_i.data[PauseW-1:0];
        REG_CHANGE_FLASH: change_flash_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign code       = in_i.error_code;

  always_comb begin
    act_l       = active_q;
    pend_l      = pending_q;
    slot_d      = slot_q;
    count_d     = count_q;
    change_d    = change_q;
    prev_mode_d = prev_mode_q;
    chg_l       = change_q;
    dark        = 1'b0;
    pat_d       = PatDark;
    slot_inc    = slot_q + timer_t'(1);
    cnt_inc     = count_q + count_t'(1);

    // latch reported error by priority
    if (code != NoError) begin
      if (pend_l == NoError || code < pend_l) pend_l = code;
      if (act_l == NoError || code < act_l) act_l = code;
    end
    active_d  = act_l;
    pending_d = pend_l;

    // blink slot sequencing
    if (act_l != NoError) begin
      slot_d = slot_inc;
      if (slot_inc > blink_period_q) begin
        slot_d  = '0;
        count_d = cnt_inc;
        if (cnt_inc > count_t'({2'b00, act_l})) begin
          count_d   = count_t'(0) - count_t'({2'b00, pause_slots_q});
          active_d  = pend_l;
          pending_d = NoError;
        end
      end
      if (slot_d > dark_after_q && count_d > count_t'(0)) dark = 1'b1;
    end

    // mode change flash and mode patterns
    if (!dark) begin
      if (in_i.system_mode != prev_mode_q) begin
        chg_l       = change_flash_q;
        prev_mode_d = in_i.system_mode;
      end
      change_d = chg_l;
      if (chg_l != '0) begin
        change_d = chg_l - timer_t'(1);
        pat_d    = PatDark;
      end else begin
        case (mode_e'(in_i.system_mode)) inside
          MODE_IDLE:           pat_d = PatGreenBoth;
          MODE_SPIN:           pat_d = in_i.angle_bit ? PatRedBoth : PatGreenBoth;
          MODE_SUN, MODE_SUN_SIM:
            pat_d = in_i.rotation_phase[PhaseW-1] ? PatRear : PatFront;
          default:             pat_d = PatDark;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= NoError;
      pending_q   <= NoError;
      slot_q      <= '0;
      count_q     <= '0;
      change_q    <= '0;
      prev_mode_q <= MODE_OFF;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        active_q    <= active_d;
        pending_q   <= pending_d;
        slot_q      <= slot_d;
        count_q     <= count_d;
        change_q    <= change_d;
        prev_mode_q <= prev_mode_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pat_q   <= pat_d;
      shown_q <= active_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.led_pattern = pat_q;
  assign out_o.shown_error = shown_q;

endmodule

`default_nettype wire

FILE: design/lbci_checker.sv
// ----------------------------------------------------------------------------
// lbci_checker
// port level checks of the led blink code indicator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lbci_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] led_pattern_i,
  input logic [3:0] shown_error_i
);

  // a stalled result holds its payload
  `LBCI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(led_pattern_i) && $stable(shown_error_i))

  // an empty output register never blocks the input
  `LBCI_ASSERT(a_in_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // every input transfer yields a result in the next cycle
  `LBCI_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i)

  // a result appears only after an input transfer
  `LBCI_ASSERT(a_no_invented, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i))

endmodule

bind led_blink_code_indicator lbci_checker u_lbci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .led_pattern_i (out_o.led_pattern),
  .shown_error_i (out_o.shown_error)
);

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// tick stream checks for the led blink code indicator
// ----------------------------------------------------------------------------
// every accepted tick is run through a behavioral model of the error latch,
// the blink slot counter, the mode change blanking and the mode patterns.
// each result on out_o is compared field by field with the oldest predicted
// result. directed tests cover the reset values, the patterns, blink codes
// and the longest blanking, then random phases rewrite all registers in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import lbci_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned MaxReports = 40;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned TicksPerPhase = 225;

  typedef logic [ModeW-1:0]  mode_t;
  typedef logic [PhaseW-1:0] phase_t;

  localparam code_t  TopError  = 4'd1;
  localparam code_t  LastError = 4'd15;
  localparam phase_t RearStart = 8'd128;

  typedef struct packed {
    pat_t  led_pattern;
    code_t shown_error;
  } indicator_t;

  logic clk;
  logic rst_n;

  lbci_cfg_if cfg_bus ();
  lbci_in_if  tick_bus ();
  lbci_out_if led_bus ();

  led_blink_code_indicator uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (tick_bus),
    .out_o  (led_bus)
  );

  // model registers and state
  timer_t period_reg     = RstBlinkPeriod;
  timer_t dark_after_reg = RstDarkAfter;
  pause_t pause_reg      = RstPauseSlots;
  timer_t flash_reg      = RstChangeFlash;

  code_t  active_code  = NoError;
  code_t  pending_code = NoError;
  timer_t slot_ticks   = '0;
  count_t blink_slot   = '0;
  mode_t  last_mode    = MODE_OFF;
  timer_t flash_left   = '0;

  indicator_t  predicted_leds[$];
  bit          idling_on;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic indicator_t advance_indicator(code_t code, mode_t mode, logic angle,
                                                   phase_t phase);
    indicator_t res;
    if (code != NoError) begin
      if (pending_code == NoError || code < pending_code) pending_code = code;
      if (active_code == NoError || code < active_code) active_code = code;
    end
    if (active_code != NoError) begin
      slot_ticks = slot_ticks + timer_t'(1);
      if (slot_ticks > period_reg) begin
        slot_ticks = '0;
        blink_slot = blink_slot + count_t'(1);
        if (int'(blink_slot) > int'(active_code)) begin
          blink_slot   = count_t'(-int'(pause_reg));
          active_code  = pending_code;
          pending_code = NoError;
        end
      end
      // counted blink, dark part of the slot
      if (slot_ticks > dark_after_reg && blink_slot > count_t'(0)) begin
        res.led_pattern = PatDark;
        res.shown_error = active_code;
        return res;
      end
    end
    if (mode != last_mode) begin
      flash_left = flash_reg;
      last_mode  = mode;
    end
    if (flash_left != '0) begin
      flash_left      = flash_left - timer_t'(1);
      res.led_pattern = PatDark;
    end else begin
      case (mode) inside
        MODE_IDLE:             res.led_pattern = PatGreenBoth;
        MODE_SPIN:             res.led_pattern = angle ? PatRedBoth : PatGreenBoth;
        MODE_SUN, MODE_SUN_SIM: res.led_pattern = (phase < RearStart) ? PatFront : PatRear;
        default:               res.led_pattern = PatDark;
      endcase
    end
    res.shown_error = active_code;
    return res;
  endfunction

  // result side: random stall bursts
  always @(negedge clk) begin
    if (!idling_on) begin
      led_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      led_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      led_bus.ready <= 1'b0;
    end else begin
      led_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    indicator_t want;
    if (rst_n && led_bus.valid && led_bus.ready) begin
      if (predicted_leds.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: result with none expected, actual pattern=%h error=%0d",
                   $time, led_bus.led_pattern, led_bus.shown_error);
      end else begin
        want = predicted_leds.pop_front();
        if (led_bus.led_pattern !== want.led_pattern) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: led_pattern expected %h actual %h", $time, want.led_pattern,
                     led_bus.led_pattern);
        end
        if (led_bus.shown_error !== want.shown_error) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: shown_error expected %0d actual %0d", $time, want.shown_error,
                     led_bus.shown_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** led_blink_code_indicator: FAILED **");
      $finish;
    end
  end

  task automatic send_tick(code_t code, mode_t mode, logic angle, phase_t phase);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      tick_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    tick_bus.valid          <= 1'b1;
    tick_bus.error_code     <= code;
    tick_bus.system_mode    <= mode;
    tick_bus.angle_bit      <= angle;
    tick_bus.rotation_phase <= phase;
    do @(posedge clk); while (!tick_bus.ready);
    predicted_leds.push_back(advance_indicator(code, mode, angle, phase));
    @(negedge clk);
  endtask

  task automatic drain();
    tick_bus.valid <= 1'b0;
    while (predicted_leds.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, cfg_data_t value);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_BLINK_PERIOD: period_reg = value;
      REG_DARK_AFTER:   dark_after_reg = value;
      REG_PAUSE_SLOTS:  pause_reg = value[PauseW-1:0];
      REG_CHANGE_FLASH: flash_reg = value;
      default:          ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_values();
    send_tick(NoError, MODE_OFF, 1'b0, 8'd0);
    send_tick(NoError, MODE_OFF, 1'b1, 8'd255);
    send_tick(NoError, MODE_OFF, 1'b0, RearStart);
    drain();
  endtask

  task automatic test_mode_patterns();
    write_reg(REG_CHANGE_FLASH, 16'd0);
    for (int m = 0; m < 8; m++) begin
      send_tick(NoError, mode_t'(m), 1'b0, RearStart - 8'd1);
      send_tick(NoError, mode_t'(m), 1'b1, RearStart);
    end
    // short blanking after a change
    write_reg(REG_CHANGE_FLASH, 16'd3);
    repeat (5) send_tick(NoError, MODE_SPIN, 1'b1, 8'd0);
    drain();
  endtask

  task automatic test_blink_codes();
    write_reg(REG_BLINK_PERIOD, 16'd1);
    write_reg(REG_DARK_AFTER, 16'd0);
    write_reg(REG_PAUSE_SLOTS, 16'd0);
    write_reg(REG_CHANGE_FLASH, 16'd0);
    send_tick(code_t'(3), MODE_IDLE, 1'b0, 8'd0);
    repeat (4) send_tick(NoError, MODE_IDLE, 1'b0, 8'd0);
    send_tick(code_t'(2), MODE_IDLE, 1'b0, 8'd0);
    send_tick(TopError, MODE_IDLE, 1'b0, 8'd0);
    send_tick(LastError, MODE_IDLE, 1'b0, 8'd0);
    repeat (12) send_tick(NoError, MODE_IDLE, 1'b0, 8'd0);
    drain();
  endtask

  // longest blanking after a mode change
  task automatic test_flash_maximum();
    write_reg(REG_CHANGE_FLASH, 16'hFFFF);
    repeat (40)
      send_tick(NoError, MODE_SUN, 1'($urandom_range(0, 1)), phase_t'($urandom_range(0, 255)));
    write_reg(REG_CHANGE_FLASH, 16'd0);
    repeat (4)
      send_tick(NoError, MODE_IDLE, 1'($urandom_range(0, 1)), phase_t'($urandom_range(0, 255)));
    drain();
  endtask

  task automatic test_random();
    mode_t     cur_mode;
    code_t     code;
    cfg_data_t period;
    cfg_data_t pause_word;
    cur_mode = MODE_IDLE;
    for (int p = 0; p < RandomPhases; p++) begin
      idling_on  = (p != RandomPhases - 1) && (p != 2);
      period     = ($urandom_range(0, 7) == 0) ? cfg_data_t'($urandom_range(20, 40))
                                               : cfg_data_t'($urandom_range(1, 10));
      pause_word = cfg_data_t'($urandom());
      if (p == 0) begin
        period     = 16'd1;
        pause_word[PauseW-1:0] = 4'd15;
      end else if (p == 1) begin
        pause_word[PauseW-1:0] = 4'd0;
      end
      write_reg(REG_BLINK_PERIOD, period);
      write_reg(REG_DARK_AFTER, (p == 0) ? 16'd0 : cfg_data_t'($urandom_range(0, period + 2)));
      write_reg(REG_PAUSE_SLOTS, pause_word);
      write_reg(REG_CHANGE_FLASH, (p == 0) ? 16'd0 : cfg_data_t'($urandom_range(0, 12)));
      repeat (TicksPerPhase) begin
        if ($urandom_range(0, 29) == 0) cur_mode = mode_t'($urandom_range(0, 7));
        code = ($urandom_range(0, 6) == 0) ? code_t'($urandom_range(1, 15)) : NoError;
        send_tick(code, cur_mode, 1'($urandom_range(0, 1)), phase_t'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    idling_on               = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.addr            = '0;
    cfg_bus.data            = '0;
    tick_bus.valid          = 1'b0;
    tick_bus.error_code     = NoError;
    tick_bus.system_mode    = MODE_OFF;
    tick_bus.angle_bit      = 1'b0;
    tick_bus.rotation_phase = '0;
    led_bus.ready           = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idling_on = 1'b1;
    test_reset_values();
    test_mode_patterns();
    test_blink_codes();
    idling_on = 1'b0;
    test_flash_maximum();
    test_random();
    idling_on = 1'b0;
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("** led_blink_code_indicator: PASSED **");
    end else begin
      $display("** led_blink_code_indicator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/lbci_pkg.sv
design/lbci_cfg_if.sv
design/lbci_in_if.sv
design/lbci_out_if.sv
design/led_blink_code_indicator.sv
design/lbci_checker.sv
dv/testbench.sv
